// ===== rtl/tpfs_pkg.sv =====
// Shared types, constants and page-selection helpers for the two-page variable store.
// No dependencies; RTL modules use it by scoped names, bench files import it.
package tpfs_pkg;

    localparam int unsigned NUM_CFG    = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned KEY_W      = 16;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned WORD_W     = 32;

    localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0]  ERASED_KEY  = 16'hFFFF;
    localparam logic [DATA_W-1:0] ERASED_DATA = 16'hFFFF;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef key_t [NUM_CFG-1:0] key_arr_t;

    typedef enum logic [1:0] {
        PG_ERASED    = 2'd0,
        PG_RECEIVING = 2'd1,
        PG_VALID     = 2'd2
    } page_state_t;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_FORMAT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_VALID  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic none;
        logic pg;
    } page_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 op_ld;
        logic                 lk_start;
        logic                 lk_page;
        logic                 lk_use_cfg;
        logic [CFG_IDX_W-1:0] kidx;
        logic                 ap_en;
        logic                 ap_page;
        logic                 ap_copy;
        logic [1:0]           clr_fill;
        logic                 out_ld;
        logic                 out_useval;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] room;
        logic       lk_done;
        logic       lk_found;
        logic       cfg_is_cur;
    } dp_stat_t;

    function automatic page_sel_t read_page(page_state_t p0, page_state_t p1);
        page_sel_t r;
        r = '{none: 1'b1, pg: 1'b0};
        if (p0 == PG_VALID) begin
            r = '{none: 1'b0, pg: 1'b0};
        end else if (p1 == PG_VALID) begin
            r = '{none: 1'b0, pg: 1'b1};
        end
        return r;
    endfunction

    function automatic page_sel_t write_page(page_state_t p0, page_state_t p1);
        page_sel_t r;
        r = '{none: 1'b1, pg: 1'b0};
        if (p1 == PG_VALID) begin
            r = '{none: 1'b0, pg: (p0 == PG_RECEIVING) ? 1'b0 : 1'b1};
        end else if (p0 == PG_VALID) begin
            r = '{none: 1'b0, pg: (p1 == PG_RECEIVING) ? 1'b1 : 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/tpfs_cmd_if.sv =====
// Request channel: valid/ready handshake carrying action, key and data.
// Uses no package.
interface tpfs_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] var_key;
    logic [15:0] var_data;

    modport source (output valid, output action, output var_key, output var_data, input ready);
    modport sink   (input valid, input action, input var_key, input var_data, output ready);
endinterface

// ===== rtl/tpfs_rsp_if.sv =====
// Response channel: valid/ready handshake carrying read value and status.
// Uses no package.
interface tpfs_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic [1:0]  status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ===== rtl/tpfs_regs.sv =====
// APB-style configuration registers holding the keys carried across a page transfer.
// Depends on tpfs_pkg.
module tpfs_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tpfs_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [tpfs_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tpfs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    output tpfs_pkg::key_arr_t                    keys
);

    tpfs_pkg::key_arr_t                 keys_reg;
    logic [tpfs_pkg::CFG_IDX_W-1:0]     idx;
    logic                               idx_ok;
    logic                               wr_en;

    assign idx    = paddr[tpfs_pkg::CFG_ADDR_W-1:2];
    assign idx_ok = (idx < tpfs_pkg::CFG_IDX_W'(tpfs_pkg::NUM_CFG));
    assign wr_en  = psel && penable && pwrite && idx_ok;
    assign pready = 1'b1;
    assign keys   = keys_reg;

    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = tpfs_pkg::APB_DATA_W'(keys_reg[idx]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpfs_pkg::NUM_CFG; i++)
            begin
                keys_reg[i] <= tpfs_pkg::KEY_W'(i);
            end
        end
        else if (wr_en)
        begin
            keys_reg[idx] <= pwdata[tpfs_pkg::KEY_W-1:0];
        end
    end

endmodule

// ===== rtl/tpfs_dp.sv =====
// Datapath: slot memory, per-page fill counts, backward key scan and response value.
// Depends on tpfs_pkg.
module tpfs_dp
#(
    parameter int unsigned PAGE_SLOTS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpfs_pkg::dp_cmd_t     cmd,
    output tpfs_pkg::dp_stat_t    stat,
    input  tpfs_pkg::key_arr_t    keys,
    input  tpfs_pkg::key_t        in_key,
    input  tpfs_pkg::data_t       in_data,
    output tpfs_pkg::data_t       out_value
);

    localparam int unsigned SLOT_W = $clog2(PAGE_SLOTS);
    localparam int unsigned FILL_W = $clog2(PAGE_SLOTS + 1);
    localparam logic [FILL_W-1:0] FILL_EMPTY = FILL_W'(1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(PAGE_SLOTS);

    logic [tpfs_pkg::WORD_W-1:0] mem [0:1][0:PAGE_SLOTS-1];

    tpfs_pkg::key_t                 cur_key_reg;
    tpfs_pkg::data_t                cur_data_reg;
    logic [FILL_W-1:0]              fill_reg [2];
    logic                           lk_busy_reg;
    logic                           lk_pend_reg;
    logic                           lk_fast_reg;
    logic [SLOT_W-1:0]              lk_ptr_reg;
    logic                           lk_page_reg;
    tpfs_pkg::key_t                 lk_key_reg;
    tpfs_pkg::data_t                lk_value_reg;
    logic                           lk_done_reg;
    logic                           lk_found_reg;
    logic [tpfs_pkg::WORD_W-1:0]    rd_data_reg;
    tpfs_pkg::data_t                out_value_reg;

    tpfs_pkg::key_t                 sel_key;
    tpfs_pkg::key_t                 lk_src_key;
    logic [tpfs_pkg::WORD_W-1:0]    ap_word;
    logic [SLOT_W-1:0]              ap_slot;
    logic [FILL_W-1:0]              start_fill;
    logic                           rd_match;
    logic                           rd_issue;

    assign sel_key    = keys[cmd.kidx];
    assign lk_src_key = cmd.lk_use_cfg ? sel_key : cur_key_reg;
    assign ap_word    = cmd.ap_copy ? {sel_key, lk_value_reg} : {cur_key_reg, cur_data_reg};
    assign ap_slot    = fill_reg[cmd.ap_page][SLOT_W-1:0];
    assign start_fill = fill_reg[cmd.lk_page] - FILL_EMPTY;
    assign rd_match   = lk_pend_reg
                        && (rd_data_reg[tpfs_pkg::WORD_W-1:tpfs_pkg::DATA_W] == lk_key_reg);
    assign rd_issue   = lk_busy_reg && !lk_fast_reg && !rd_match && (lk_ptr_reg != '0);

    assign stat.room[0]    = (fill_reg[0] != FILL_FULL);
    assign stat.room[1]    = (fill_reg[1] != FILL_FULL);
    assign stat.lk_done    = lk_done_reg;
    assign stat.lk_found   = lk_found_reg;
    assign stat.cfg_is_cur = (sel_key == cur_key_reg);
    assign out_value       = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg[0]  <= FILL_EMPTY;
            fill_reg[1]  <= FILL_EMPTY;
            lk_busy_reg  <= 1'b0;
            lk_pend_reg  <= 1'b0;
            lk_fast_reg  <= 1'b0;
            lk_ptr_reg   <= '0;
            lk_page_reg  <= 1'b0;
            lk_key_reg   <= '0;
            lk_value_reg <= '0;
            lk_done_reg  <= 1'b0;
            lk_found_reg <= 1'b0;
        end
        else
        begin
            lk_done_reg <= 1'b0;
            // an all-ones pair leaves the slot erased, so the count holds
            if (cmd.ap_en && (ap_word != tpfs_pkg::ERASED_WORD))
            begin
                fill_reg[cmd.ap_page] <= fill_reg[cmd.ap_page] + FILL_EMPTY;
            end
            for (int p = 0; p < 2; p++)
            begin
                if (cmd.clr_fill[p])
                begin
                    fill_reg[p] <= FILL_EMPTY;
                end
            end
            if (cmd.lk_start)
            begin
                lk_busy_reg  <= 1'b1;
                lk_pend_reg  <= 1'b0;
                lk_ptr_reg   <= start_fill[SLOT_W-1:0];
                lk_page_reg  <= cmd.lk_page;
                lk_key_reg   <= lk_src_key;
                lk_value_reg <= '0;
                // erased slots above the fill count match the all-ones key first
                lk_fast_reg  <= (lk_src_key == tpfs_pkg::ERASED_KEY) && stat.room[cmd.lk_page];
            end
            else if (lk_busy_reg)
            begin
                priority if (lk_fast_reg)
                begin
                    lk_busy_reg  <= 1'b0;
                    lk_done_reg  <= 1'b1;
                    lk_found_reg <= 1'b1;
                    lk_value_reg <= tpfs_pkg::ERASED_DATA;
                end
                else if (rd_match)
                begin
                    lk_busy_reg  <= 1'b0;
                    lk_done_reg  <= 1'b1;
                    lk_found_reg <= 1'b1;
                    lk_value_reg <= rd_data_reg[tpfs_pkg::DATA_W-1:0];
                end
                else if (lk_ptr_reg != '0)
                begin
                    lk_ptr_reg  <= lk_ptr_reg - SLOT_W'(1);
                    lk_pend_reg <= 1'b1;
                end
                else
                begin
                    lk_busy_reg  <= 1'b0;
                    lk_done_reg  <= 1'b1;
                    lk_found_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_ld)
        begin
            cur_key_reg  <= in_key;
            cur_data_reg <= in_data;
        end
        if (cmd.ap_en)
        begin
            mem[cmd.ap_page][ap_slot] <= ap_word;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[lk_page_reg][lk_ptr_reg];
        end
        if (cmd.out_ld)
        begin
            out_value_reg <= cmd.out_useval ? lk_value_reg : '0;
        end
    end

    a_append_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ap_en |-> !lk_busy_reg)
        else $error("append while a scan is running");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lk_start |-> !lk_busy_reg)
        else $error("scan started while one is running");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] >= FILL_EMPTY) && (fill_reg[0] <= FILL_FULL)
        && (fill_reg[1] >= FILL_EMPTY) && (fill_reg[1] <= FILL_FULL))
        else $error("fill count out of range");

endmodule

// ===== rtl/tpfs_ctrl.sv =====
// Controller: sequences read, write, page transfer and format; owns page states.
// Depends on tpfs_pkg.
module tpfs_ctrl
#(
    parameter int unsigned NUM_KEYS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_action,
    output logic                  in_ready,
    output logic                  out_valid,
    output logic [1:0]            out_status,
    input  logic                  out_ready,
    output tpfs_pkg::dp_cmd_t     cmd,
    input  tpfs_pkg::dp_stat_t    stat
);

    localparam int unsigned KW = $clog2(NUM_KEYS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_XF_FIRST,
        S_XF_KEY,
        S_XF_WAIT,
        S_FIN
    } state_t;

    state_t                  state_reg,      state_next;
    logic [1:0]              action_reg,     action_next;
    tpfs_pkg::page_state_t   pg0_reg,        pg0_next;
    tpfs_pkg::page_state_t   pg1_reg,        pg1_next;
    logic                    oldp_reg,       oldp_next;
    logic [KW-1:0]           k_reg,          k_next;
    tpfs_pkg::status_t       res_st_reg,     res_st_next;
    logic                    res_useval_reg, res_useval_next;
    logic                    out_valid_reg,  out_valid_next;
    tpfs_pkg::status_t       out_status_reg, out_status_next;

    tpfs_pkg::page_sel_t     rp;
    tpfs_pkg::page_sel_t     wp;

    assign rp         = tpfs_pkg::read_page(pg0_reg, pg1_reg);
    assign wp         = tpfs_pkg::write_page(pg0_reg, pg1_reg);
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        pg0_next        = pg0_reg;
        pg1_next        = pg1_reg;
        oldp_next       = oldp_reg;
        k_next          = k_reg;
        res_st_next     = res_st_reg;
        res_useval_next = res_useval_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        cmd             = '0;
        cmd.kidx        = tpfs_pkg::CFG_IDX_W'(k_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op_ld   = 1'b1;
                    action_next = in_action;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_useval_next = 1'b0;
                state_next      = S_FIN;
                res_st_next     = tpfs_pkg::ST_OK;
                unique case (tpfs_pkg::action_t'(action_reg))
                    tpfs_pkg::ACT_READ:
                    begin
                        if (rp.none)
                        begin
                            res_st_next = tpfs_pkg::ST_NO_VALID;
                        end
                        else
                        begin
                            cmd.lk_start = 1'b1;
                            cmd.lk_page  = rp.pg;
                            state_next   = S_RD_WAIT;
                        end
                    end
                    tpfs_pkg::ACT_WRITE:
                    begin
                        priority if (wp.none || rp.none)
                        begin
                            res_st_next = tpfs_pkg::ST_NO_VALID;
                        end
                        else if (stat.room[wp.pg])
                        begin
                            cmd.ap_en   = 1'b1;
                            cmd.ap_page = wp.pg;
                        end
                        else
                        begin
                            // mark the other page receiving and start the transfer
                            oldp_next = rp.pg;
                            if (rp.pg)
                            begin
                                pg0_next = tpfs_pkg::PG_RECEIVING;
                            end
                            else
                            begin
                                pg1_next = tpfs_pkg::PG_RECEIVING;
                            end
                            state_next = S_XF_FIRST;
                        end
                    end
                    tpfs_pkg::ACT_FORMAT:
                    begin
                        cmd.clr_fill = 2'b11;
                        pg0_next     = tpfs_pkg::PG_VALID;
                        pg1_next     = tpfs_pkg::PG_ERASED;
                    end
                    default:
                    begin
                        res_st_next = tpfs_pkg::ST_OK;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                if (stat.lk_done)
                begin
                    res_useval_next = 1'b1;
                    res_st_next     = stat.lk_found ? tpfs_pkg::ST_OK : tpfs_pkg::ST_NOT_FOUND;
                    state_next      = S_FIN;
                end
            end
            S_XF_FIRST:
            begin
                priority if (wp.none)
                begin
                    res_st_next = tpfs_pkg::ST_NO_VALID;
                    state_next  = S_FIN;
                end
                else if (stat.room[wp.pg])
                begin
                    cmd.ap_en   = 1'b1;
                    cmd.ap_page = wp.pg;
                    k_next      = '0;
                    state_next  = S_XF_KEY;
                end
                else
                begin
                    res_st_next = tpfs_pkg::ST_FULL;
                    state_next  = S_FIN;
                end
            end
            S_XF_KEY:
            begin
                priority if (k_reg == KW'(NUM_KEYS))
                begin
                    // commit: new page valid, old page erased
                    if (oldp_reg)
                    begin
                        pg0_next = tpfs_pkg::PG_VALID;
                        pg1_next = tpfs_pkg::PG_ERASED;
                    end
                    else
                    begin
                        pg1_next = tpfs_pkg::PG_VALID;
                        pg0_next = tpfs_pkg::PG_ERASED;
                    end
                    cmd.clr_fill[oldp_reg] = 1'b1;
                    res_st_next            = tpfs_pkg::ST_OK;
                    state_next             = S_FIN;
                end
                else if (stat.cfg_is_cur)
                begin
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    cmd.lk_start   = 1'b1;
                    cmd.lk_page    = oldp_reg;
                    cmd.lk_use_cfg = 1'b1;
                    state_next     = S_XF_WAIT;
                end
            end
            S_XF_WAIT:
            begin
                if (stat.lk_done)
                begin
                    priority if (!stat.lk_found)
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_XF_KEY;
                    end
                    else if (wp.none)
                    begin
                        res_st_next = tpfs_pkg::ST_NO_VALID;
                        state_next  = S_FIN;
                    end
                    else if (stat.room[wp.pg])
                    begin
                        cmd.ap_en   = 1'b1;
                        cmd.ap_page = wp.pg;
                        cmd.ap_copy = 1'b1;
                        k_next      = k_reg + KW'(1);
                        state_next  = S_XF_KEY;
                    end
                    else
                    begin
                        res_st_next = tpfs_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_ld      = 1'b1;
                    cmd.out_useval  = res_useval_reg;
                    out_valid_next  = 1'b1;
                    out_status_next = res_st_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= '0;
            pg0_reg        <= tpfs_pkg::PG_VALID;
            pg1_reg        <= tpfs_pkg::PG_ERASED;
            oldp_reg       <= 1'b0;
            k_reg          <= '0;
            res_st_reg     <= tpfs_pkg::ST_OK;
            res_useval_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= tpfs_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            action_reg     <= action_next;
            pg0_reg        <= pg0_next;
            pg1_reg        <= pg1_next;
            oldp_reg       <= oldp_next;
            k_reg          <= k_next;
            res_st_reg     <= res_st_next;
            res_useval_reg <= res_useval_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    a_one_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !((pg0_reg == tpfs_pkg::PG_VALID) && (pg1_reg == tpfs_pkg::PG_VALID)))
        else $error("both pages valid");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.lk_done |-> ((state_reg == S_RD_WAIT) || (state_reg == S_XF_WAIT)))
        else $error("scan finished outside a wait state");

endmodule

// ===== rtl/two_page_flash_variable_store.sv =====
// Top level of the two-page log-structured variable store.
// Depends on tpfs_pkg, tpfs_cmd_if, tpfs_rsp_if, tpfs_regs, tpfs_dp and tpfs_ctrl.
//
// Usage:
//   cmd carries one request per transfer: action (read, write, format), var_key
//   and var_data. rsp returns exactly one transfer per request: read_value and
//   status. Both use valid/ready; a transfer happens when both are high.
//   The APB port sets key_0..key_5 at byte addresses 0,4,..,20; write it only
//   while the block is idle. pready is tied high.
// Sequencing:
//   One request is in flight at a time. A format, an unused action or a write
//   with room goes from the dispatch state to the finish state, which loads the
//   response register. A read scans the valid page backwards one slot per cycle
//   from its fill count. A full write page starts a transfer: the new pair goes
//   to the other page, then the old page is scanned once per configured key
//   other than the written one. The slot memory's single read port sets the scan rate.
// Reset:
//   Page 0 is valid, page 1 erased, keys hold 0..5. Each page keeps a fill
//   count, so the slot memory needs no clearing pass and requests are taken
//   as soon as reset is released.
// Stalls:
//   The response waits in an output register; the next request is accepted
//   while it waits, and its own response is held until the first one moves.
module two_page_flash_variable_store
#(
    parameter int unsigned PAGE_SLOTS = 256,
    parameter int unsigned NUM_KEYS   = 6
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    tpfs_cmd_if.sink                              cmd,
    tpfs_rsp_if.source                            rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tpfs_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [tpfs_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tpfs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    tpfs_pkg::key_arr_t   keys;
    tpfs_pkg::dp_cmd_t    dp_cmd;
    tpfs_pkg::dp_stat_t   dp_stat;
    tpfs_pkg::data_t      out_value;
    logic                 in_ready;
    logic                 out_valid;
    logic [1:0]           out_status;

    // key registers
    tpfs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .keys    (keys)
    );

    // sequencer: decides each step, advances page states
    tpfs_ctrl #(.NUM_KEYS(NUM_KEYS)) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_action  (cmd.action),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_status (out_status),
        .out_ready  (rsp.ready),
        .cmd        (dp_cmd),
        .stat       (dp_stat)
    );

    // slot memory, fill counts and scan engine
    tpfs_dp #(.PAGE_SLOTS(PAGE_SLOTS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .keys      (keys),
        .in_key    (cmd.var_key),
        .in_data   (cmd.var_data),
        .out_value (out_value)
    );

    assign cmd.ready      = in_ready;
    assign rsp.valid      = out_valid;
    assign rsp.status     = out_status;
    assign rsp.read_value = out_value;

endmodule

// ===== bench/tb_store_model.sv =====
// Behavioral predictor of the two-page variable store.
// Depends on tpfs_pkg for field types, page states, actions and status codes.
package tb_store_model;
    import tpfs_pkg::*;

    localparam int unsigned SLOTS = 256;
    localparam int unsigned KEYS  = 6;

    logic [31:0]  flash_words [2*SLOTS];
    page_state_t  pg_state [2];
    key_t         carry_keys [KEYS];

    function automatic void wipe_page(int p);
        for (int s = 0; s < SLOTS; s++) flash_words[p*SLOTS+s] = ERASED_WORD;
    endfunction

    function automatic void format_all();
        wipe_page(0);
        wipe_page(1);
        pg_state[0] = PG_VALID;
        pg_state[1] = PG_ERASED;
    endfunction

    function automatic void store_reset();
        for (int i = 0; i < KEYS; i++) carry_keys[i] = key_t'(i);
        format_all();
    endfunction

    // -1 means no valid page
    function automatic int valid_page();
        if (pg_state[0] == PG_VALID) return 0;
        if (pg_state[1] == PG_VALID) return 1;
        return -1;
    endfunction

    function automatic int target_page();
        if (pg_state[1] == PG_VALID) return (pg_state[0] == PG_RECEIVING) ? 0 : 1;
        if (pg_state[0] == PG_VALID) return (pg_state[1] == PG_RECEIVING) ? 1 : 0;
        return -1;
    endfunction

    function automatic bit find_latest(int p, key_t k, output data_t v);
        v = '0;
        for (int s = SLOTS-1; s >= 1; s--) begin
            if (flash_words[p*SLOTS+s][31:16] == k) begin
                v = flash_words[p*SLOTS+s][15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic status_t append_pair(key_t k, data_t d);
        int p;
        p = target_page();
        if (p < 0) return ST_NO_VALID;
        for (int s = 1; s < SLOTS; s++) begin
            if (flash_words[p*SLOTS+s] == ERASED_WORD) begin
                flash_words[p*SLOTS+s] = {k, d};
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    function automatic status_t move_page(key_t k, data_t d);
        int oldp, newp;
        status_t st;
        data_t v;
        oldp = valid_page();
        if (oldp < 0) return ST_NO_VALID;
        newp = oldp ^ 1;
        pg_state[newp] = PG_RECEIVING;
        st = append_pair(k, d);
        if (st != ST_OK) return st;
        for (int i = 0; i < KEYS; i++) begin
            if (carry_keys[i] == k) continue;
            if (!find_latest(oldp, carry_keys[i], v)) continue;
            st = append_pair(carry_keys[i], v);
            if (st != ST_OK) return st;
        end
        pg_state[newp] = PG_VALID;
        pg_state[oldp] = PG_ERASED;
        wipe_page(oldp);
        return ST_OK;
    endfunction

    function automatic void apply_request(logic [1:0] act, key_t k, data_t d,
                                          output data_t val, output status_t st);
        int p;
        val = '0;
        st  = ST_OK;
        if (act == ACT_READ) begin
            p = valid_page();
            if (p < 0) st = ST_NO_VALID;
            else if (!find_latest(p, k, val)) begin
                val = '0;
                st  = ST_NOT_FOUND;
            end
        end else if (act == ACT_WRITE) begin
            st = append_pair(k, d);
            if (st == ST_FULL) st = move_page(k, d);
        end else if (act == ACT_FORMAT) begin
            format_all();
        end
    endfunction
endpackage

// ===== bench/tb_top.sv =====
// Self-checking bench for two_page_flash_variable_store: directed and random requests,
// APB key setup between phases, random stalls on both channels.
// Depends on tpfs_pkg, tpfs_cmd_if, tpfs_rsp_if, tb_store_model and the top-level RTL.
module tb_top;
    import tpfs_pkg::*;
    import tb_store_model::*;

    localparam int STALL_LIMIT = 20000;   // transfer-free cycles before giving up
    localparam int DRAIN_WAIT  = 1700;    // worst transfer length plus margin
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata, prdata;
    logic pready;

    tpfs_cmd_if cmd_ch();
    tpfs_rsp_if rsp_ch();

    two_page_flash_variable_store dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd_ch.sink), .rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        data_t   value;
        status_t status;
    } answer_t;

    answer_t answers_due[$];
    int      fail_count;
    int      idle_cycles;
    bit      rsp_hold;          // long receiver hold-off request
    key_t    key_pool[KEYS];    // keys used by random writes and reads

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Compare each response transfer with the oldest prediction.
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected response value=%h status=%0d", $time,
                         rsp_ch.read_value, rsp_ch.status);
                fail_count++;
            end
            else
            begin
                exp_a = answers_due.pop_front();
                if (rsp_ch.read_value !== exp_a.value)
                begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             exp_a.value, rsp_ch.read_value);
                    fail_count++;
                end
                if (rsp_ch.status !== exp_a.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_a.status, rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random ready, mostly short gaps, sometimes long ones;
    // a requested hold-off keeps ready low for a long counted stretch.
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_hold)
            begin
                rsp_ch.ready <= 1'b0;
                for (int c = 0; c < 3000; c++) @(posedge clk);
                rsp_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
                  $urandom_range(0, 3);
            if (gap == 0 || $urandom_range(0, 1))
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                for (int c = 1; c < gap; c++) @(posedge clk);
            end
        end
    end

    // Offer one request, hold it until transferred, then predict its answer.
    // Valid was dropped at the previous transfer, so wait out any random gap before raising it.
    task automatic send_request(logic [1:0] act, key_t k, data_t d, bit gaps = 1);
        int gap;
        answer_t a;
        gap = 0;
        if (gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        end
        repeat (gap + 1) @(posedge clk);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.action   <= act;
        cmd_ch.var_key  <= k;
        cmd_ch.var_data <= d;
        do @(posedge clk); while (!cmd_ch.ready);
        apply_request(act, k, d, a.value, a.status);
        answers_due.push_back(a);
        cmd_ch.valid <= 1'b0;
    endtask

    // Wait for every response, then let the block settle.
    task automatic drain();
        while (answers_due.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Setup then access; the caller drops psel after the last access.
    task automatic apb_write(int idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        carry_keys[idx] = key_t'(v);
    endtask

    task automatic set_keys(key_t k0, key_t k1, key_t k2, key_t k3, key_t k4, key_t k5);
        key_t ks[KEYS];
        ks = '{k0, k1, k2, k3, k4, k5};
        drain();
        for (int i = 0; i < KEYS; i++) apb_write(i, {16'h0, ks[i]});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        key_pool = ks;
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(0, 9))
            0: return key_t'($urandom_range(0, 65534));
            1: return 16'hFFFF;
            default: return key_pool[$urandom_range(0, KEYS-1)];
        endcase
    endfunction

    // Extremes, every action and the listed corner cases.
    task automatic test_directed();
        send_request(ACT_READ, 16'd0, 16'h1234);          // not found on fresh page
        send_request(ACT_READ, 16'hFFFF, 16'h0);          // matches erased slot
        send_request(ACT_WRITE, 16'd0, 16'h0000);
        send_request(ACT_WRITE, 16'd1, 16'hFFFF);
        send_request(ACT_WRITE, 16'hFFFE, 16'hA5A5);
        send_request(ACT_WRITE, 16'hFFFF, 16'hFFFF);      // looks erased
        send_request(ACT_WRITE, 16'd2, 16'h5A5A);         // lands in same slot
        send_request(ACT_READ, 16'd1, 16'h0);
        send_request(ACT_READ, 16'hFFFE, 16'h0);
        send_request(ACT_READ, 16'hFFFF, 16'h0);
        send_request(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(ACT_FORMAT, 16'h0, 16'h0);
        send_request(ACT_READ, 16'd0, 16'h0);
    endtask

    // Fill the page to force a transfer, with keys configured by the caller.
    task automatic test_page_transfer(int writes);
        for (int i = 0; i < writes; i++)
            send_request(ACT_WRITE, key_pool[i % KEYS], data_t'($urandom));
        for (int i = 0; i < KEYS; i++) send_request(ACT_READ, key_pool[i], 16'h0);
    endtask

    // Mostly writes and reads to configured keys, plus noise.
    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_request(ACT_WRITE, pick_key(), data_t'($urandom));
            else if (r < 97)
                send_request(ACT_READ, pick_key(), data_t'($urandom));
            else if (r < 99)
                send_request(ACT_FORMAT, key_t'($urandom), data_t'($urandom));
            else
                send_request(ACT_UNUSED, key_t'($urandom), data_t'($urandom));
        end
    endtask

    // Keep offering requests back to back while the receiver holds off.
    task automatic test_backpressure();
        rsp_hold = 1'b1;
        for (int i = 0; i < 8; i++) send_request(ACT_WRITE, key_pool[i % KEYS], 16'(i), 0);
    endtask

    initial
    begin
        fail_count   = 0;
        idle_cycles  = 0;
        rsp_hold     = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action   = '0;
        cmd_ch.var_key  = '0;
        cmd_ch.var_data = '0;
        store_reset();
        for (int i = 0; i < KEYS; i++) key_pool[i] = key_t'(i);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        // Duplicates: skipped or copied per listing.
        set_keys(16'd7, 16'd7, 16'hFFFE, 16'd0, 16'd9, 16'd9);
        test_page_transfer(300);
        // Extremes of the key range.
        set_keys(16'hFFFE, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001);
        test_random(150);
        // All keys alike: each listing is the written key, so none is copied.
        set_keys(16'd3, 16'd3, 16'd3, 16'd3, 16'd3, 16'd3);
        test_page_transfer(300);
        // Back to distinct keys for the bulk of random traffic.
        set_keys(16'h0010, 16'h0020, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00);
        test_random(220);

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== two_page_flash_variable_store.f =====
rtl/tpfs_pkg.sv
rtl/tpfs_cmd_if.sv
rtl/tpfs_rsp_if.sv
rtl/tpfs_regs.sv
rtl/tpfs_dp.sv
rtl/tpfs_ctrl.sv
rtl/two_page_flash_variable_store.sv
bench/tb_store_model.sv
bench/tb_top.sv
